@@ rtl/otpfc_pkg.sv @@
// Package for the fuse controller: beat types, bus register codes and constants.
// No dependencies; every other file but the RAM imports it.
package otpfc_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] bus_offset;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        busy_res;
        logic        error;
    } rsp_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] idx;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] LAYOUT_BANKED = 2'd0;
    localparam logic [1:0] LAYOUT_LINEAR = 2'd1;
    localparam logic [1:0] LAYOUT_ALIAS  = 2'd2;
    localparam logic [1:0] LAYOUT_RSVD   = 2'd3;

    localparam logic [9:0] REG_CTRL      = 10'h000;
    localparam logic [9:0] REG_CTRL_SET  = 10'h001;
    localparam logic [9:0] REG_CTRL_CLR  = 10'h002;
    localparam logic [9:0] REG_TIMING    = 10'h004;
    localparam logic [9:0] REG_DATA      = 10'h008;
    localparam logic [9:0] REG_READ_CTRL = 10'h00C;
    localparam logic [9:0] REG_FUSE_DATA = 10'h010;

    localparam logic [2:0] CFG_ADDR_LAYOUT = 3'd0;

    localparam int BIT_BUSY   = 8;
    localparam int BIT_ERROR  = 9;
    localparam int BIT_RELOAD = 10;
    localparam int BIT_SENSE  = 0;

    localparam logic [15:0] UNLOCK_KEY    = 16'h3E77;
    localparam logic [7:0]  BANK_LAST     = 8'h2F;
    localparam logic [7:0]  BANK_GAP_SLOT = 8'h10;
    localparam logic [7:0]  SHADOW_SLOT0  = 8'h40;
    localparam logic [7:0]  ALIAS_SLOT    = 8'h45;
    localparam logic [7:0]  ALIAS_WORD    = 8'h04;

endpackage

@@ rtl/otpfc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module otpfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/otpfc_decode.sv @@
// Shadow window decoder: maps a bus offset to a shadow word index per layout.
// Depends on otpfc_pkg.
module otpfc_decode import otpfc_pkg::*; #(
    parameter int FUSE_WORDS = 128
) (
    input  logic [11:0] bus_offset,
    input  logic [1:0]  layout,
    output slot_t       slot
);

    localparam logic [7:0] FUSE_WORDS_W = 8'(FUSE_WORDS);

    logic [7:0] win;
    logic [7:0] idx;
    logic       in_gap;

    always_comb
    begin
        win    = 8'(bus_offset[11:4] - SHADOW_SLOT0);
        idx    = win;
        in_gap = 1'b0;
        if (layout != LAYOUT_LINEAR)
        begin
            if (layout == LAYOUT_ALIAS && bus_offset[11:4] == ALIAS_SLOT)
            begin
                idx = ALIAS_WORD;
            end
            else if (win <= BANK_LAST)
            begin
                idx = win;
            end
            else if (win < 8'(BANK_LAST + 8'd1 + BANK_GAP_SLOT))
            begin
                in_gap = 1'b1;
            end
            else
            begin
                idx = 8'(win - BANK_GAP_SLOT);
            end
        end
        slot.hit = (bus_offset[11:10] != 2'b00) && !in_gap && (idx < FUSE_WORDS_W);
        slot.idx = idx[6:0];
    end

endmodule

@@ rtl/otpfc_ctrl.sv @@
// Sequencer for the fuse controller: register file, read-modify-write of the fuse RAM,
// shadow RAM writes, response register. Depends on otpfc_pkg and otpfc_decode.
module otpfc_ctrl import otpfc_pkg::*; #(
    parameter int FUSE_WORDS = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  req_t                          req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output rsp_t                          rsp,
    input  logic [1:0]                    layout,
    output logic                          fuse_we,
    output logic [$clog2(FUSE_WORDS)-1:0] fuse_waddr,
    output logic [31:0]                   fuse_wdata,
    output logic                          fuse_re,
    output logic [$clog2(FUSE_WORDS)-1:0] fuse_raddr,
    input  logic [31:0]                   fuse_rdata,
    output logic                          shad_we,
    output logic [$clog2(FUSE_WORDS)-1:0] shad_waddr,
    output logic [31:0]                   shad_wdata,
    output logic                          shad_re,
    output logic [$clog2(FUSE_WORDS)-1:0] shad_raddr,
    input  logic [31:0]                   shad_rdata
);

    localparam int AW = $clog2(FUSE_WORDS);
    localparam logic [7:0]    FUSE_WORDS_W = 8'(FUSE_WORDS);
    localparam logic [AW-1:0] LAST_WORD    = AW'(FUSE_WORDS - 1);

    state_t            state_reg, state_next;
    req_t              item_reg, item_next;
    slot_t             slot_reg, slot_next;
    slot_t             slot_in;
    logic              fuse_vq_reg, fuse_vq_next;
    logic              shad_vq_reg, shad_vq_next;
    logic [FUSE_WORDS-1:0] fuse_valid_reg, fuse_valid_next;
    logic [FUSE_WORDS-1:0] shad_valid_reg, shad_valid_next;
    logic [6:0]        addr_reg, addr_next;
    logic [15:0]       unlock_reg, unlock_next;
    logic              busy_reg, busy_next;
    logic              error_reg, error_next;
    logic              reload_reg, reload_next;
    logic [21:0]       timing_reg, timing_next;
    logic [31:0]       sensed_reg, sensed_next;
    logic [11:0]       count_reg, count_next;
    logic [AW-1:0]     rl_idx_reg, rl_idx_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              accept;
    logic              fire;
    logic [31:0]       ctrl_word;
    logic              addr_ok;
    logic [31:0]       fuse_word;
    logic [9:0]        reg_idx;
    logic              ctrl_wr;
    logic              ctrl_req;
    logic [31:0]       ctrl_v;
    logic [11:0]       count_dec;
    logic [31:0]       rd_data;

    otpfc_decode #(
        .FUSE_WORDS (FUSE_WORDS)
    ) u_decode (
        .bus_offset (req.bus_offset),
        .layout     (layout),
        .slot       (slot_in)
    );

    assign accept    = (state_reg == ST_IDLE) && req_valid;
    assign fire      = (state_reg == ST_EXEC) && !(rsp_valid_reg && rsp_stall);
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign fuse_re    = accept;
    assign fuse_raddr = (busy_reg && reload_reg) ? rl_idx_reg : addr_reg[AW-1:0];
    assign shad_re    = accept;
    assign shad_raddr = slot_in.idx[AW-1:0];

    assign ctrl_word = {unlock_reg, 5'b0, reload_reg, error_reg, busy_reg, 1'b0, addr_reg};
    assign addr_ok   = ({1'b0, addr_reg} < FUSE_WORDS_W);
    assign fuse_word = fuse_vq_reg ? fuse_rdata : 32'h0;
    assign reg_idx   = item_reg.bus_offset[11:2];
    assign count_dec = (count_reg != 12'h000) ? 12'(count_reg - 12'h001) : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        slot_next       = slot_reg;
        fuse_vq_next    = fuse_vq_reg;
        shad_vq_next    = shad_vq_reg;
        fuse_valid_next = fuse_valid_reg;
        shad_valid_next = shad_valid_reg;
        addr_next       = addr_reg;
        unlock_next     = unlock_reg;
        busy_next       = busy_reg;
        error_next      = error_reg;
        reload_next     = reload_reg;
        timing_next     = timing_reg;
        sensed_next     = sensed_reg;
        count_next      = count_reg;
        rl_idx_next     = rl_idx_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        fuse_we         = 1'b0;
        fuse_waddr      = addr_reg[AW-1:0];
        fuse_wdata      = fuse_word | item_reg.write_data;
        shad_we         = 1'b0;
        shad_waddr      = slot_reg.idx[AW-1:0];
        shad_wdata      = item_reg.write_data;
        ctrl_wr         = 1'b0;
        ctrl_req        = 1'b0;
        ctrl_v          = 32'h0;
        rd_data         = 32'h0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next    = req;
                    slot_next    = slot_in;
                    fuse_vq_next = fuse_valid_reg[fuse_raddr];
                    shad_vq_next = shad_valid_reg[shad_raddr];
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                    case (item_reg.command)
                        CMD_TICK:
                        begin
                            if (busy_reg && reload_reg)
                            begin
                                shad_we    = 1'b1;
                                shad_waddr = rl_idx_reg;
                                shad_wdata = fuse_word;
                                if (rl_idx_reg == LAST_WORD)
                                begin
                                    reload_next = 1'b0;
                                    busy_next   = 1'b0;
                                    rl_idx_next = '0;
                                end
                                else
                                begin
                                    rl_idx_next = AW'(rl_idx_reg + 1'b1);
                                end
                            end
                            else if (busy_reg)
                            begin
                                count_next = count_dec;
                                if (count_dec == 12'h000)
                                begin
                                    busy_next = 1'b0;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (item_reg.bus_offset[11:10] != 2'b00)
                            begin
                                rd_data = (slot_reg.hit && shad_vq_reg) ? shad_rdata : 32'h0;
                            end
                            else if (reg_idx inside {REG_CTRL, REG_CTRL_SET, REG_CTRL_CLR})
                            begin
                                rd_data = ctrl_word;
                            end
                            else if (reg_idx == REG_TIMING)
                            begin
                                rd_data = {10'b0, timing_reg};
                            end
                            else if (reg_idx == REG_FUSE_DATA)
                            begin
                                rd_data = sensed_reg;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (item_reg.bus_offset[11:10] != 2'b00)
                            begin
                                shad_we = slot_reg.hit;
                            end
                            else
                            begin
                                case (reg_idx)
                                    REG_CTRL:
                                    begin
                                        ctrl_wr  = 1'b1;
                                        ctrl_v   = item_reg.write_data;
                                        ctrl_req = item_reg.write_data[BIT_RELOAD];
                                    end
                                    REG_CTRL_SET:
                                    begin
                                        ctrl_wr  = 1'b1;
                                        ctrl_v   = ctrl_word | item_reg.write_data;
                                        ctrl_req = item_reg.write_data[BIT_RELOAD];
                                    end
                                    REG_CTRL_CLR:
                                    begin
                                        ctrl_wr = 1'b1;
                                        ctrl_v  = ctrl_word & ~item_reg.write_data;
                                    end
                                    REG_TIMING:
                                    begin
                                        timing_next = item_reg.write_data[21:0];
                                    end
                                    REG_DATA:
                                    begin
                                        if (busy_reg || unlock_reg != UNLOCK_KEY || !addr_ok)
                                        begin
                                            error_next = 1'b1;
                                        end
                                        else
                                        begin
                                            fuse_we     = 1'b1;
                                            unlock_next = 16'h0;
                                            busy_next   = 1'b1;
                                            count_next  = timing_reg[11:0];
                                        end
                                    end
                                    REG_READ_CTRL:
                                    begin
                                        if (item_reg.write_data[BIT_SENSE])
                                        begin
                                            if (busy_reg || !addr_ok)
                                            begin
                                                error_next = 1'b1;
                                            end
                                            else
                                            begin
                                                sensed_next = fuse_word;
                                                busy_next   = 1'b1;
                                                count_next  = {6'b0, timing_reg[21:16]};
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (ctrl_wr)
                    begin
                        addr_next   = ctrl_v[6:0];
                        unlock_next = ctrl_v[31:16];
                        error_next  = ctrl_v[BIT_ERROR];
                        if (ctrl_req)
                        begin
                            if (busy_reg)
                            begin
                                error_next = 1'b1;
                            end
                            else
                            begin
                                reload_next = 1'b1;
                                rl_idx_next = '0;
                                busy_next   = 1'b1;
                                count_next  = 12'h000;
                            end
                        end
                    end

                    if (fuse_we)
                    begin
                        fuse_valid_next[fuse_waddr] = 1'b1;
                    end
                    if (shad_we)
                    begin
                        shad_valid_next[shad_waddr] = 1'b1;
                    end

                    rsp_valid_next = 1'b1;
                    if (item_reg.command == CMD_NONE)
                    begin
                        rsp_next = '0;
                    end
                    else
                    begin
                        rsp_next.read_data = rd_data;
                        rsp_next.busy_res  = busy_next;
                        rsp_next.error     = error_next;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fuse_valid_reg <= '0;
            shad_valid_reg <= '0;
            addr_reg       <= '0;
            unlock_reg     <= '0;
            busy_reg       <= 1'b0;
            error_reg      <= 1'b0;
            reload_reg     <= 1'b0;
            timing_reg     <= '0;
            sensed_reg     <= '0;
            count_reg      <= '0;
            rl_idx_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fuse_valid_reg <= fuse_valid_next;
            shad_valid_reg <= shad_valid_next;
            addr_reg       <= addr_next;
            unlock_reg     <= unlock_next;
            busy_reg       <= busy_next;
            error_reg      <= error_next;
            reload_reg     <= reload_next;
            timing_reg     <= timing_next;
            sensed_reg     <= sensed_next;
            count_reg      <= count_next;
            rl_idx_reg     <= rl_idx_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        slot_reg    <= slot_next;
        fuse_vq_reg <= fuse_vq_next;
        shad_vq_reg <= shad_vq_next;
        rsp_reg     <= rsp_next;
    end

endmodule

@@ rtl/otp_fuse_controller_top.sv @@
// Top level of the fuse controller: layout register port, fuse and shadow RAMs.
// Depends on otpfc_pkg, otpfc_ram, otpfc_ctrl.
//
//   channel  | handshake                 | beat
//   ---------+---------------------------+--------------------------------
//   req      | req_valid / req_stall     | req_t: command, offset, data
//   rsp      | rsp_valid / rsp_stall     | rsp_t: read data, busy, error
//   config   | psel/penable/pwrite/pready| address_layout at byte 0
//
// Each beat passes through two steps: one to issue the fuse and shadow RAM reads,
// one to update registers, write back and load the response register.
// A stalled response holds the update step until rsp_stall drops.
// Reset clears all control state and the per-word valid bits; no clearing pass.
module otp_fuse_controller_top import otpfc_pkg::*; #(
    parameter int FUSE_WORDS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(FUSE_WORDS);

    logic [1:0]    layout_reg, layout_next;
    logic          fuse_we, fuse_re, shad_we, shad_re;
    logic [AW-1:0] fuse_waddr, fuse_raddr, shad_waddr, shad_raddr;
    logic [31:0]   fuse_wdata, fuse_rdata, shad_wdata, shad_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == CFG_ADDR_LAYOUT) ? {30'b0, layout_reg} : 32'h0;

    always_comb
    begin
        layout_next = layout_reg;
        if (psel && penable && pwrite && pready && paddr == CFG_ADDR_LAYOUT)
        begin
            layout_next = (pwdata[1:0] == LAYOUT_RSVD) ? LAYOUT_BANKED : pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg <= LAYOUT_BANKED;
        end
        else
        begin
            layout_reg <= layout_next;
        end
    end

    otpfc_ctrl #(
        .FUSE_WORDS (FUSE_WORDS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .layout     (layout_reg),
        .fuse_we    (fuse_we),
        .fuse_waddr (fuse_waddr),
        .fuse_wdata (fuse_wdata),
        .fuse_re    (fuse_re),
        .fuse_raddr (fuse_raddr),
        .fuse_rdata (fuse_rdata),
        .shad_we    (shad_we),
        .shad_waddr (shad_waddr),
        .shad_wdata (shad_wdata),
        .shad_re    (shad_re),
        .shad_raddr (shad_raddr),
        .shad_rdata (shad_rdata)
    );

    otpfc_ram #(
        .WIDTH (32),
        .DEPTH (FUSE_WORDS)
    ) u_fuse_ram (
        .clk   (clk),
        .we    (fuse_we),
        .waddr (fuse_waddr),
        .wdata (fuse_wdata),
        .re    (fuse_re),
        .raddr (fuse_raddr),
        .rdata (fuse_rdata)
    );

    otpfc_ram #(
        .WIDTH (32),
        .DEPTH (FUSE_WORDS)
    ) u_shadow_ram (
        .clk   (clk),
        .we    (shad_we),
        .waddr (shad_waddr),
        .wdata (shad_wdata),
        .re    (shad_re),
        .raddr (shad_raddr),
        .rdata (shad_rdata)
    );

endmodule

@@ rtl/otpfc_checker.sv @@
// Port-level checks for the fuse controller top level, with the bind that attaches them.
// Depends on otpfc_pkg and otp_fuse_controller_top.
module otpfc_checker import otpfc_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request side not stalled after a beat was taken");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
        else $error("response beat missing two cycles after request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response beat changed");

endmodule

bind otp_fuse_controller_top otpfc_checker u_checker (.*);
